// ===== design/multi_waveform_phase_oscillator_macros.svh =====
// assertion macros for the multi-waveform phase oscillator
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_MACROS_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_MACROS_SVH

// same-cycle implication
`define MWPO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MWPO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mwpo_pkg.sv =====
// shared types, codes and the quarter-wave sine table of the oscillator
package mwpo_pkg;

   localparam int SINE_ENTRIES = 256;
   localparam int SINE_SHIFT = $clog2(SINE_ENTRIES);
   localparam int IDX_BITS = SINE_SHIFT;

   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 31;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PHASE_INC = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WAVE_TYPE = 2'd1;

   localparam logic [2:0] WAVE_SINE = 3'd0;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
   localparam logic [2:0] WAVE_SAW = 3'd2;
   localparam logic [2:0] WAVE_SQUARE = 3'd3;
   localparam logic [2:0] WAVE_CUBED_SINE = 3'd4;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_PEEK = 1'b1;

   typedef logic [30:0] sine_table_type [SINE_ENTRIES];

   typedef struct packed {
      logic [IDX_BITS-1:0] addr;
      logic                at_top;
   } rom_req_type;

   typedef struct packed {
      logic [30:0] base;
      logic [30:0] step;
   } rom_rsp_type;

   // taylor sum to the 13th power, q30, capped at one
   function automatic logic [30:0] sine_entry(input int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      x = (HALF_PI_Q30 * longint'(k)) / SINE_ENTRIES;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum = (term > sum) ? 64'd0 : sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum = (term > sum) ? 64'd0 : sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum = (term > sum) ? 64'd0 : sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + term;
      if (sum > Q30_ONE) begin
         sum = Q30_ONE;
      end
      return sum[30:0];
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         t[k] = sine_entry(k);
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();
   localparam logic [30:0] SINE_TOP = sine_entry(SINE_ENTRIES);

endpackage

// ===== design/mwpo_req_if.sv =====
// request channel: command and phase offset
interface mwpo_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] phase_offset;

   modport source (output valid, output cmd, output phase_offset, input ready);
   modport sink (input valid, input cmd, input phase_offset, output ready);
endinterface

// ===== design/mwpo_rsp_if.sv =====
// response channel: one signed sample per beat
interface mwpo_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// ===== design/multi_waveform_phase_oscillator.sv =====
// multi-waveform phase oscillator top level
//
// Phase-accumulator oscillator. A req_chan beat with cmd advance adds the
// phase increment register to the phase and returns the waveform at the new
// phase; cmd peek returns the waveform at phase plus phase_offset and leaves
// the phase alone. Each request gives exactly one rsp_chan beat. The csr
// port writes the phase increment (index 0) and wave type (index 1); write
// only while no request is in flight.
// One item is worked at a time by a small sequencer around a single 32x32
// multiplier. From the request beat the sequencer enters ST_SETUP; square and
// unknown types then go to ST_OUT, triangle and saw pass through the shared
// multiplier, sine reads the table first, and cubed sine makes more passes
// for its cube. req_chan.ready comes back in the cycle after the response
// beat, so no new request is taken before the last response is taken.
// The response is held in an output register; a stalled receiver holds the
// block with its sample steady until taken. Synchronous reset clears the
// phase, both registers and the sequencer, with no response pending.
`include "multi_waveform_phase_oscillator_macros.svh"

module multi_waveform_phase_oscillator #(
   parameter int PHASE_BITS = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   mwpo_req_if.sink                              req_chan,
   mwpo_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [mwpo_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [mwpo_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int DOWN_SHIFT = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
   localparam int UP_SHIFT = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
   localparam logic [31:0] FULL_SCALE = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [63:0] RND30 = 64'd1 << 29;
   localparam logic [63:0] RND31 = 64'd1 << 30;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_ROM = 3'd2;
   localparam logic [2:0] ST_MUL = 3'd3;
   localparam logic [2:0] ST_POST = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   localparam logic [1:0] STG_INTERP = 2'd0;
   localparam logic [1:0] STG_CUBE_SQ = 2'd1;
   localparam logic [1:0] STG_CUBE_MUL = 2'd2;
   localparam logic [1:0] STG_FINAL = 2'd3;

   logic [2:0]             state_ff, state_in;
   logic [PHASE_BITS-1:0]  phase_acc_ff, phase_acc_in;
   logic [30:0]            inc_ff, inc_in;
   logic [2:0]             wave_ff, wave_in;
   logic [31:0]            u_ff, u_in;
   logic                   neg_ff, neg_in;
   logic [29:0]            f_ff, f_in;
   logic [1:0]             stage_ff, stage_in;
   logic [31:0]            op_a_ff, op_a_in;
   logic [31:0]            op_b_ff, op_b_in;
   logic [63:0]            prod_ff, prod_in;
   logic [30:0]            m_ff, m_in;
   logic [30:0]            tlo_ff, tlo_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;

   logic                   req_beat;
   logic [63:0]            inc_wide;
   logic [63:0]            off_wide;
   logic [PHASE_BITS-1:0]  phase_sum;
   logic [63:0]            u_wide;
   logic [30:0]            r_sel;
   logic [63:0]            pos;
   logic [30:0]            m_sum;
   logic [63:0]            rnd30;
   logic [63:0]            rnd31;
   logic [SAMPLE_BITS-1:0] fs_s;
   logic [SAMPLE_BITS-1:0] mag_s;

   mwpo_pkg::rom_req_type  rom_req;
   mwpo_pkg::rom_rsp_type  rom_rsp;

   mwpo_sine_rom u_rom (
      .clock  (clock),
      .rd_req (rom_req),
      .rd_rsp (rom_rsp)
   );

   assign req_beat = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_OUT);
   assign rsp_chan.sample = sample_ff;

   // phase alignment to the accumulator width
   assign inc_wide = (64'({1'b0, inc_ff}) << DOWN_SHIFT) >> UP_SHIFT;
   assign off_wide = (64'(req_chan.phase_offset) << DOWN_SHIFT) >> UP_SHIFT;
   assign phase_sum = (req_chan.cmd == mwpo_pkg::CMD_PEEK)
                    ? phase_acc_ff + off_wide[PHASE_BITS-1:0]
                    : phase_acc_ff + inc_wide[PHASE_BITS-1:0];
   assign u_wide = (64'(phase_sum) >> DOWN_SHIFT) << UP_SHIFT;

   // quadrant mirror and table position
   assign r_sel = u_ff[30] ? (31'h4000_0000 - {1'b0, u_ff[29:0]}) : {1'b0, u_ff[29:0]};
   assign pos = 64'(r_sel) << mwpo_pkg::SINE_SHIFT;
   assign rom_req.addr = pos[30 +: mwpo_pkg::IDX_BITS];
   assign rom_req.at_top = pos[30 + mwpo_pkg::IDX_BITS];

   assign rnd30 = (prod_ff + RND30) >> 30;
   assign rnd31 = (prod_ff + RND31) >> 31;
   assign m_sum = tlo_ff + rnd30[30:0];
   assign fs_s = FULL_SCALE[SAMPLE_BITS-1:0];
   assign mag_s = rnd30[SAMPLE_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      phase_acc_in = phase_acc_ff;
      inc_in = inc_ff;
      wave_in = wave_ff;
      u_in = u_ff;
      neg_in = neg_ff;
      f_in = f_ff;
      stage_in = stage_ff;
      op_a_in = op_a_ff;
      op_b_in = op_b_ff;
      prod_in = prod_ff;
      m_in = m_ff;
      tlo_in = tlo_ff;
      sample_in = sample_ff;

      if (csr_we) begin
         case (csr_index)
            mwpo_pkg::CSR_PHASE_INC: inc_in = csr_wdata;
            mwpo_pkg::CSR_WAVE_TYPE: wave_in = csr_wdata[2:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_chan.cmd == mwpo_pkg::CMD_ADVANCE) begin
                  phase_acc_in = phase_sum;
               end
               u_in = u_wide[31:0];
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            stage_in = STG_FINAL;
            case (wave_ff)
               mwpo_pkg::WAVE_SINE, mwpo_pkg::WAVE_CUBED_SINE: begin
                  f_in = pos[29:0];
                  neg_in = u_ff[31];
                  state_in = ST_ROM;
               end
               mwpo_pkg::WAVE_TRIANGLE: begin
                  op_a_in = u_ff[31] ? 32'(33'h1_0000_0000 - {1'b0, u_ff}) : u_ff;
                  op_b_in = FULL_SCALE;
                  state_in = ST_MUL;
               end
               mwpo_pkg::WAVE_SAW: begin
                  op_a_in = u_ff;
                  op_b_in = FULL_SCALE;
                  state_in = ST_MUL;
               end
               mwpo_pkg::WAVE_SQUARE: begin
                  sample_in = u_ff[31] ? SAMPLE_BITS'(0) - fs_s : fs_s;
                  state_in = ST_OUT;
               end
               default: begin
                  sample_in = '0;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_ROM: begin
            tlo_in = rom_rsp.base;
            op_a_in = {1'b0, rom_rsp.step};
            op_b_in = {2'b0, f_ff};
            stage_in = STG_INTERP;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = 64'(op_a_ff) * 64'(op_b_ff);
            state_in = ST_POST;
         end
         ST_POST: begin
            state_in = ST_MUL;
            case (stage_ff)
               STG_INTERP: begin
                  m_in = m_sum;
                  op_a_in = {1'b0, m_sum};
                  if (wave_ff == mwpo_pkg::WAVE_CUBED_SINE) begin
                     op_b_in = {1'b0, m_sum};
                     stage_in = STG_CUBE_SQ;
                  end else begin
                     op_b_in = FULL_SCALE;
                     stage_in = STG_FINAL;
                  end
               end
               STG_CUBE_SQ: begin
                  op_a_in = rnd30[31:0];
                  op_b_in = {1'b0, m_ff};
                  stage_in = STG_CUBE_MUL;
               end
               STG_CUBE_MUL: begin
                  op_a_in = rnd30[31:0];
                  op_b_in = FULL_SCALE;
                  stage_in = STG_FINAL;
               end
               default: begin
                  state_in = ST_OUT;
                  case (wave_ff)
                     mwpo_pkg::WAVE_SINE, mwpo_pkg::WAVE_CUBED_SINE:
                        sample_in = neg_ff ? SAMPLE_BITS'(0) - mag_s : mag_s;
                     mwpo_pkg::WAVE_TRIANGLE:
                        sample_in = mag_s - fs_s;
                     mwpo_pkg::WAVE_SAW:
                        sample_in = rnd31[SAMPLE_BITS-1:0] - fs_s;
                     default:
                        sample_in = '0;
                  endcase
               end
            endcase
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_acc_ff <= '0;
         inc_ff <= '0;
         wave_ff <= mwpo_pkg::WAVE_SINE;
      end else begin
         state_ff <= state_in;
         phase_acc_ff <= phase_acc_in;
         inc_ff <= inc_in;
         wave_ff <= wave_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      neg_ff <= neg_in;
      f_ff <= f_in;
      stage_ff <= stage_in;
      op_a_ff <= op_a_in;
      op_b_ff <= op_b_in;
      prod_ff <= prod_in;
      m_ff <= m_in;
      tlo_ff <= tlo_in;
      sample_ff <= sample_in;
   end

   `MWPO_ASSERT_NOW(a_ready_excl_valid, clock, reset, req_chan.ready, !rsp_chan.valid, "request taken while a response is pending")
   `MWPO_ASSERT_NEXT(a_one_rsp_per_req, clock, reset, rsp_chan.valid && rsp_chan.ready, !rsp_chan.valid, "response repeated after its beat")
   `MWPO_ASSERT_NEXT(a_phase_holds, clock, reset, !(req_beat && req_chan.cmd == mwpo_pkg::CMD_ADVANCE), $stable(phase_acc_ff), "phase moved without an advance beat")

endmodule

// ===== design/mwpo_sine_rom.sv =====
// quarter-wave sine lookup with registered base and slope to the next entry
module mwpo_sine_rom (
   input  logic                 clock,
   input  mwpo_pkg::rom_req_type rd_req,
   output mwpo_pkg::rom_rsp_type rd_rsp
);

   logic [mwpo_pkg::IDX_BITS-1:0] addr_nx;
   logic [30:0]                   lo;
   logic [30:0]                   hi;
   mwpo_pkg::rom_rsp_type         rsp_in;
   mwpo_pkg::rom_rsp_type         rsp_ff;

   assign addr_nx = rd_req.addr + mwpo_pkg::IDX_BITS'(1);

   always_comb begin
      lo = mwpo_pkg::SINE_TABLE[rd_req.addr];
      if (rd_req.addr == mwpo_pkg::IDX_BITS'(mwpo_pkg::SINE_ENTRIES - 1)) begin
         hi = mwpo_pkg::SINE_TOP;
      end else begin
         hi = mwpo_pkg::SINE_TABLE[addr_nx];
      end
      if (rd_req.at_top) begin
         rsp_in.base = mwpo_pkg::SINE_TOP;
         rsp_in.step = 31'd0;
      end else begin
         rsp_in.base = lo;
         rsp_in.step = hi - lo;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rd_rsp = rsp_ff;

endmodule

// ===== bench/tb.sv =====
// testbench for the multi-waveform phase oscillator: directed table, random phases, own predictor
module tb;

   localparam int TABLE_N = 256;
   localparam longint unsigned UNIT_Q30 = 64'd1073741824;
   localparam longint unsigned HALF_Q30 = 64'd536870912;
   localparam longint unsigned ARC_QUARTER = 64'd1686629713;
   localparam longint FS = 64'sd32767;
   localparam longint TWO32 = 64'sd4294967296;
   localparam logic [mwpo_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [mwpo_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int ITEMS_PER_PHASE = 560;

   typedef struct packed {
      logic        cmd;
      logic [31:0] offset;
   } req_beat_type;

   typedef struct packed {
      logic                              is_reg;
      logic [mwpo_pkg::CSR_IDX_BITS-1:0] reg_idx;
      logic [30:0]                       reg_data;
      logic                              cmd;
      logic [31:0]                       offset;
      logic                              typed;
      logic signed [15:0]                sample;
   } step_row_type;

   localparam int DIRECTED_ROWS = 31;
   localparam step_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_ADVANCE, 32'h0000_0000, 1'b1, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h4000_0000, 1'b1, 16'sd32767},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h8000_0000, 1'b1, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'hC000_0000, 1'b1,
        -16'sd32767},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'hFFFF_FFFF, 1'b0, 16'sd0},
      '{1'b1, mwpo_pkg::CSR_WAVE_TYPE, 31'(mwpo_pkg::WAVE_TRIANGLE), mwpo_pkg::CMD_ADVANCE,
        32'h0, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h0000_0000, 1'b1,
        -16'sd32767},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h8000_0000, 1'b1, 16'sd32767},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h4000_0000, 1'b1, 16'sd0},
      '{1'b1, mwpo_pkg::CSR_WAVE_TYPE, 31'(mwpo_pkg::WAVE_SAW), mwpo_pkg::CMD_ADVANCE,
        32'h0, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h0000_0000, 1'b1,
        -16'sd32767},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'hFFFF_FFFF, 1'b0, 16'sd0},
      '{1'b1, mwpo_pkg::CSR_WAVE_TYPE, 31'(mwpo_pkg::WAVE_SQUARE), mwpo_pkg::CMD_ADVANCE,
        32'h0, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h7FFF_FFFF, 1'b1, 16'sd32767},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h8000_0000, 1'b1,
        -16'sd32767},
      '{1'b1, mwpo_pkg::CSR_WAVE_TYPE, 31'(mwpo_pkg::WAVE_CUBED_SINE), mwpo_pkg::CMD_ADVANCE,
        32'h0, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h4000_0000, 1'b1, 16'sd32767},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'hC000_0000, 1'b1,
        -16'sd32767},
      // unknown wave type, upper data bits set
      '{1'b1, mwpo_pkg::CSR_WAVE_TYPE, 31'h7FFF_FFFF, mwpo_pkg::CMD_ADVANCE, 32'h0, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_ADVANCE, 32'h0000_0000, 1'b1, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h5A5A_5A5A, 1'b1, 16'sd0},
      '{1'b1, mwpo_pkg::CSR_PHASE_INC, 31'h7FFF_FFFF, mwpo_pkg::CMD_ADVANCE, 32'h0, 1'b0, 16'sd0},
      '{1'b1, mwpo_pkg::CSR_WAVE_TYPE, 31'(mwpo_pkg::WAVE_SAW), mwpo_pkg::CMD_ADVANCE,
        32'h0, 1'b0, 16'sd0},
      // spare index, must not touch either register
      '{1'b1, CSR_SPARE_B, 31'd0, mwpo_pkg::CMD_ADVANCE, 32'h0, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_ADVANCE, 32'h0000_0000, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_ADVANCE, 32'h0000_0000, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_ADVANCE, 32'h0000_0000, 1'b0, 16'sd0},
      '{1'b1, mwpo_pkg::CSR_WAVE_TYPE, 31'(mwpo_pkg::WAVE_SINE), mwpo_pkg::CMD_ADVANCE,
        32'h0, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_ADVANCE, 32'h0000_0000, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h3FFF_FFFF, 1'b0, 16'sd0},
      '{1'b0, mwpo_pkg::CSR_PHASE_INC, 31'd0, mwpo_pkg::CMD_PEEK, 32'h00FF_FFFF, 1'b0, 16'sd0}
   };

   logic                               clock;
   logic                               reset;
   logic                               csr_we;
   logic [mwpo_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [mwpo_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   mwpo_req_if req_chan ();
   mwpo_rsp_if #(.SAMPLE_BITS(16)) rsp_chan ();

   multi_waveform_phase_oscillator #(
      .PHASE_BITS(32),
      .SAMPLE_BITS(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   longint unsigned    quarter_sine [TABLE_N + 1];
   logic [31:0]        osc_phase;
   logic [30:0]        osc_step;
   logic [2:0]         osc_shape;
   logic signed [15:0] expected_samples [$];
   req_beat_type       req_backlog [$];
   req_beat_type       next_beat;
   int                 src_idle_pct;
   int                 sink_idle_pct;
   int                 mismatches = 0;
   int                 cycles = 0;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   function automatic longint unsigned taylor_sine_q30(input int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      bit minus;
      x = (ARC_QUARTER * longint'(k)) / TABLE_N;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      minus = 1'b1;
      for (int n = 3; n <= 13; n += 2) begin
         term = ((term * x2) >> 30) / longint'((n - 1) * n);
         if (minus) begin
            sum = (term > sum) ? 64'd0 : sum - term;
         end else begin
            sum = sum + term;
         end
         minus = !minus;
      end
      return (sum > UNIT_Q30) ? UNIT_Q30 : sum;
   endfunction

   function automatic longint unsigned sine_mag(input logic [31:0] u, output bit neg);
      longint unsigned r;
      longint unsigned pos;
      longint unsigned i;
      longint unsigned f;
      r = u[29:0];
      if (u[30]) begin
         r = UNIT_Q30 - r;
      end
      pos = r * TABLE_N;
      i = pos >> 30;
      f = pos & (UNIT_Q30 - 1);
      neg = u[31];
      if (i >= TABLE_N) begin
         return quarter_sine[TABLE_N];
      end
      return (quarter_sine[i] * (UNIT_Q30 - f) + quarter_sine[i + 1] * f + HALF_Q30) >> 30;
   endfunction

   function automatic logic signed [15:0] scaled_q30(input longint unsigned m, input bit neg);
      longint unsigned s;
      longint sv;
      s = (m * FS + HALF_Q30) >> 30;
      sv = longint'(s);
      return 16'(neg ? -sv : sv);
   endfunction

   // t over 2^32 in [-1, 1] to the nearest sample
   function automatic logic signed [15:0] scaled_lin(input longint t);
      longint unsigned biased;
      longint unsigned v;
      biased = t + TWO32;
      v = (biased * FS + 64'd2147483648) >> 32;
      return 16'(longint'(v) - FS);
   endfunction

   function automatic logic signed [15:0] wave_value(input logic [31:0] u);
      longint unsigned m;
      longint pu;
      longint t;
      bit neg;
      pu = u;
      case (osc_shape)
         mwpo_pkg::WAVE_SINE: begin
            m = sine_mag(u, neg);
            return scaled_q30(m, neg);
         end
         mwpo_pkg::WAVE_TRIANGLE: begin
            if (!u[31]) begin
               t = 4 * pu - TWO32;
            end else begin
               t = 3 * TWO32 - 4 * pu;
            end
            return scaled_lin(t);
         end
         mwpo_pkg::WAVE_SAW: begin
            return scaled_lin(2 * pu - TWO32);
         end
         mwpo_pkg::WAVE_SQUARE: begin
            return u[31] ? 16'(-FS) : 16'(FS);
         end
         mwpo_pkg::WAVE_CUBED_SINE: begin
            m = sine_mag(u, neg);
            m = ((((m * m + HALF_Q30) >> 30) * m) + HALF_Q30) >> 30;
            return scaled_q30(m, neg);
         end
         default: begin
            return 16'sd0;
         end
      endcase
   endfunction

   function automatic logic signed [15:0] next_sample(input logic cmd, input logic [31:0] off);
      if (cmd == mwpo_pkg::CMD_ADVANCE) begin
         osc_phase = osc_phase + {1'b0, osc_step};
         return wave_value(osc_phase);
      end
      return wave_value(osc_phase + off);
   endfunction

   function automatic bit osc_busy();
      return req_backlog.size() != 0 || req_chan.valid || expected_samples.size() != 0;
   endfunction

   task automatic queue_item(input logic cmd, input logic [31:0] off, input logic typed,
                             input logic signed [15:0] typed_sample);
      logic signed [15:0] s;
      req_beat_type b;
      s = next_sample(cmd, off);
      expected_samples.push_back(typed ? typed_sample : s);
      b.cmd = cmd;
      b.offset = off;
      req_backlog.push_back(b);
   endtask

   task automatic write_reg(input logic [mwpo_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [30:0] data);
      while (osc_busy()) begin
         @(posedge clock);
      end
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == mwpo_pkg::CSR_PHASE_INC) begin
         osc_step = data;
      end else if (idx == mwpo_pkg::CSR_WAVE_TYPE) begin
         osc_shape = data[2:0];
      end
      @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.cmd <= mwpo_pkg::CMD_ADVANCE;
         req_chan.phase_offset <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            next_beat = req_backlog.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.cmd <= next_beat.cmd;
            req_chan.phase_offset <= next_beat.offset;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_samples.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
               $display("unexpected sample beat: %0d", rsp_chan.sample);
            end
         end else if (rsp_chan.sample !== expected_samples[0]) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
               $display("sample mismatch: expected %0d, actual %0d",
                        expected_samples[0], rsp_chan.sample);
            end
            void'(expected_samples.pop_front());
         end else begin
            void'(expected_samples.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [30:0] step_pick;
      logic [2:0]  shape_pick;
      logic [31:0] off;
      int          sent;
      int          seg;
      reset = 1'b1;
      csr_we <= 1'b0;
      csr_index <= mwpo_pkg::CSR_PHASE_INC;
      csr_wdata <= '0;
      osc_phase = '0;
      osc_step = '0;
      osc_shape = mwpo_pkg::WAVE_SINE;
      src_idle_pct = 16;
      sink_idle_pct = 72;
      for (int k = 0; k <= TABLE_N; k++) begin
         quarter_sine[k] = taylor_sine_q30(k);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].is_reg) begin
            write_reg(DIRECTED[r].reg_idx, DIRECTED[r].reg_data);
         end else begin
            if (csr_we) begin
               csr_we <= 1'b0;
            end
            queue_item(DIRECTED[r].cmd, DIRECTED[r].offset, DIRECTED[r].typed,
                       DIRECTED[r].sample);
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               src_idle_pct = 16;
               sink_idle_pct = 72;
            end
            1: begin
               src_idle_pct = 72;
               sink_idle_pct = 16;
            end
            default: begin
               src_idle_pct = 0;
               sink_idle_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            case ($urandom_range(5))
               0: step_pick = '0;
               1: step_pick = 31'h7FFF_FFFF;
               2: step_pick = 31'($urandom_range(1 << 20));
               3: step_pick = 31'h4000_0000 + 31'($urandom_range(255));
               default: step_pick = 31'($urandom);
            endcase
            if ($urandom_range(99) < 90) begin
               shape_pick = 3'($urandom_range(mwpo_pkg::WAVE_CUBED_SINE));
            end else begin
               shape_pick = 3'($urandom_range(7, 5));
            end
            write_reg(mwpo_pkg::CSR_PHASE_INC, step_pick);
            write_reg(mwpo_pkg::CSR_WAVE_TYPE, {28'($urandom), shape_pick});
            if ($urandom_range(5) == 0) begin
               write_reg($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, 31'($urandom));
            end
            csr_we <= 1'b0;
            seg = $urandom_range(60, 15);
            repeat (seg) begin
               case ($urandom_range(7))
                  0: off = '0;
                  1: off = 32'hFFFF_FFFF;
                  2: off = {2'($urandom_range(3)), 30'd0} + 32'($urandom_range(4)) - 32'd2;
                  default: off = $urandom;
               endcase
               queue_item($urandom_range(1) ? mwpo_pkg::CMD_PEEK : mwpo_pkg::CMD_ADVANCE, off,
                          1'b0, 16'sd0);
            end
            sent += seg;
         end
      end

      while (osc_busy()) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== multi_waveform_phase_oscillator.f =====
+incdir+design
design/mwpo_pkg.sv
design/mwpo_req_if.sv
design/mwpo_rsp_if.sv
design/mwpo_sine_rom.sv
design/multi_waveform_phase_oscillator.sv
bench/tb.sv
